/* rtl/core/bvfd_pkg.sv */
// Shared package for the byte view transform and FNV-1a digest core.
// Holds widths, codes, the queue word type and the hash step function.
// No dependencies; every other file in rtl/core but bvfd_stream_if imports it.
`default_nettype none

package bvfd_pkg;

    // Configuration port geometry: 64-bit data, registers on 8-byte strides.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_LANE = 2'd1,
        REG_KEY  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_RAW   = 3'd0,
        MODE_PLANE = 3'd1,
        MODE_CHAN  = 3'd2,
        MODE_DELTA = 3'd3,
        MODE_XOR   = 3'd4
    } mode_t;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    localparam int PLANE_GROUP = 8;
    localparam int CHAN_GROUP  = 3;

    // Emitted byte count and its saturation point.
    localparam int COUNT_W = 21;
    localparam longint unsigned MAX_STREAM_BYTES = 64'd1048576;
    localparam longint unsigned COUNT_FIELD_MAX  = (64'd1 << COUNT_W) - 64'd1;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_STREAM_BYTES < COUNT_FIELD_MAX) ? MAX_STREAM_BYTES : COUNT_FIELD_MAX);

    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified word: an optional derived byte and an end-of-stream mark.
    typedef struct packed {
        logic       emit;
        logic [7:0] val;
        logic       last;
    } op_t;

    typedef struct packed {
        logic push;
        op_t  op;
    } q_wr_t;

    typedef struct packed {
        logic avail;
        op_t  op;
    } q_rd_t;

    // One FNV-1a step. The prime is 2^40 + 0x1b3, so the product is a
    // sum of seven shifted copies.
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bvfd_stream_if.sv */
// Valid/ready channel interfaces for the input and result streams.
// Plain widths; no package dependency.
`default_nettype none

interface bvfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface bvfd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic [63:0] digest;
    logic [20:0] out_count;
    logic        run_end;

    modport source (output valid, output kind, output out_byte, output digest,
                    output out_count, output run_end, input ready);
    modport sink   (input valid, input kind, input out_byte, input digest,
                    input out_count, input run_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/byte_view_transform_fnv_digest_core.sv */
// Top level of the byte view transform core with FNV-1a 64 digest.
// Depends on bvfd_pkg, bvfd_stream_if, bvfd_front, bvfd_queue and bvfd_back.
`default_nettype none

// Raw source bytes arrive on in_ch at one word per cycle while ready is high
// and are turned into a derived byte stream by the view held in the mode
// register: raw, bit plane, channel of three, delta or xor. Each derived
// byte leaves on out_ch as a data word and is folded into a 64-bit FNV-1a
// hash and a saturating byte count. An input word marked is_last closes the
// stream with a summary word carrying the hash xor master_key and the count,
// after which the stream state returns to its reset values. The front end
// accepts one word every cycle while its four-entry queue has room; the back
// end issues one result word per cycle while out_ch is ready, so an input
// word giving both a data byte and a summary keeps its queue entry until both
// results are issued; the queue absorbs that. A word's first result passes
// the queue and then the back end's output register. Registers sit on 8-byte
// strides of the APB-style port (mode at 0x00, lane_select at 0x08,
// master_key at 0x10) and should only be written while the core is idle.
module byte_view_transform_fnv_digest_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bvfd_in_if.sink                              in_ch,
    bvfd_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bvfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bvfd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [bvfd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import bvfd_pkg::*;

    // Configuration registers.
    logic [2:0]  mode_reg;
    logic [2:0]  lane_reg;
    logic [63:0] key_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // The byte offset within a register is ignored; only the stride index counts.
    assign cfg_idx = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 3'd0;
            lane_reg <= 3'd0;
            key_reg  <= 64'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MODE: mode_reg <= pwdata[2:0];
                REG_LANE: lane_reg <= pwdata[2:0];
                REG_KEY:  key_reg  <= pwdata;
                default:  ;
            endcase
        end
    end

    // Read-back is combinational; unused addresses read as zero.
    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE: prdata = {61'd0, mode_reg};
            REG_LANE: prdata = {61'd0, lane_reg};
            REG_KEY:  prdata = key_reg;
            default:  prdata = '0;
        endcase
    end

    // The front end applies the view and pushes only words that yield results.
    bvfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .mode        (mode_reg),
        .lane_select (lane_reg),
        .q_full      (q_full),
        .q_wr        (q_wr)
    );

    // The queue lets the front keep accepting while the back issues a summary.
    bvfd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .q_rd  (q_rd)
    );

    // The back end owns the hash and count and the output register.
    bvfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rd       (q_rd),
        .pop        (q_pop),
        .master_key (key_reg),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

/* rtl/core/bvfd_front.sv */
// Front end: applies the configured view to each raw byte and classifies it.
// Depends on bvfd_pkg and bvfd_in_if; feeds bvfd_queue.
`default_nettype none

module bvfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    bvfd_in_if.sink              in_ch,
    input  wire logic [2:0]      mode,
    input  wire logic [2:0]      lane_select,
    input  wire logic            q_full,
    output bvfd_pkg::q_wr_t      q_wr
);
    import bvfd_pkg::*;

    logic [7:0] pack_reg, pack_next;
    logic [2:0] pos_reg, pos_next;
    logic [7:0] prev_reg, prev_next;
    logic       have_prev_reg, have_prev_next;

    logic       accept;
    logic       emit;
    logic [7:0] val;
    logic [7:0] pack_sh;
    logic [7:0] pack_ch;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    assign pack_sh = {pack_reg[6:0], in_ch.in_byte[lane_select]};
    assign pack_ch = (pos_reg == lane_select) ? in_ch.in_byte : pack_reg;

    always_comb
    begin
        emit           = 1'b0;
        val            = 8'd0;
        pack_next      = pack_reg;
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        unique case (mode_t'(mode))
            MODE_RAW:
            begin
                emit = 1'b1;
                val  = in_ch.in_byte;
            end
            MODE_PLANE:
            begin
                if (pos_reg >= 3'(PLANE_GROUP - 1))
                begin
                    emit      = 1'b1;
                    val       = pack_sh;
                    pos_next  = 3'd0;
                    pack_next = 8'd0;
                end
                else
                begin
                    pos_next  = pos_reg + 3'd1;
                    pack_next = pack_sh;
                end
            end
            MODE_CHAN:
            begin
                if (pos_reg >= 3'(CHAN_GROUP - 1))
                begin
                    emit      = (lane_select < 3'(CHAN_GROUP));
                    val       = pack_ch;
                    pos_next  = 3'd0;
                    pack_next = 8'd0;
                end
                else
                begin
                    pos_next  = pos_reg + 3'd1;
                    pack_next = pack_ch;
                end
            end
            MODE_DELTA:
            begin
                emit           = have_prev_reg;
                val            = in_ch.in_byte - prev_reg;
                prev_next      = in_ch.in_byte;
                have_prev_next = 1'b1;
            end
            MODE_XOR:
            begin
                emit           = have_prev_reg;
                val            = in_ch.in_byte ^ prev_reg;
                prev_next      = in_ch.in_byte;
                have_prev_next = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        // The end of a stream returns the view state to its start.
        if (in_ch.is_last)
        begin
            pack_next      = 8'd0;
            pos_next       = 3'd0;
            prev_next      = 8'd0;
            have_prev_next = 1'b0;
        end
    end

    // Only words that yield at least one result enter the queue.
    assign q_wr.push    = accept && (emit || in_ch.is_last);
    assign q_wr.op.emit = emit;
    assign q_wr.op.val  = val;
    assign q_wr.op.last = in_ch.is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_reg      <= 8'd0;
            pos_reg       <= 3'd0;
            prev_reg      <= 8'd0;
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            pack_reg      <= pack_next;
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bvfd_queue.sv */
// Small first-in first-out queue of classified words between front and back.
// Depends on bvfd_pkg for the word type and depth.
`default_nettype none

module bvfd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bvfd_pkg::q_wr_t q_wr,
    output logic                 full,
    input  wire logic            pop,
    output bvfd_pkg::q_rd_t      q_rd
);
    import bvfd_pkg::*;

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_rd.avail = (cnt_reg != '0);
    assign q_rd.op    = slot_reg[head_reg];
    assign do_pop     = pop && q_rd.avail;

    always_comb
    begin
        head_next = do_pop ? head_reg + QPTR_W'(1) : head_reg;
        tail_next = q_wr.push ? tail_reg + QPTR_W'(1) : tail_reg;
        cnt_next  = cnt_reg + QCNT_W'(q_wr.push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            slot_reg[tail_reg] <= q_wr.op;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bvfd_back.sv */
// Back end: hashes derived bytes, counts them and issues result words.
// Depends on bvfd_pkg and bvfd_out_if; drains bvfd_queue.
`default_nettype none

module bvfd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bvfd_pkg::q_rd_t q_rd,
    output logic                 pop,
    input  wire logic [63:0]     master_key,
    bvfd_out_if.source           out_ch
);
    import bvfd_pkg::*;

    logic [63:0]        hash_reg, hash_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               data_done_reg, data_done_next;
    logic               out_valid_reg, out_valid_next;

    logic               out_kind_reg, out_kind_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [63:0]        out_digest_reg, out_digest_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_run_end_reg, out_run_end_next;

    logic load;
    logic take;

    assign load = !out_valid_reg || out_ch.ready;
    assign take = load && q_rd.avail;

    always_comb
    begin
        hash_next        = hash_reg;
        count_next       = count_reg;
        data_done_next   = data_done_reg;
        out_valid_next   = load ? q_rd.avail : out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_byte_next    = out_byte_reg;
        out_digest_next  = out_digest_reg;
        out_count_next   = out_count_reg;
        out_run_end_next = out_run_end_reg;
        pop              = 1'b0;
        if (take)
        begin
            if (q_rd.op.emit && !data_done_reg)
            begin
                // Data word; when a summary follows, the entry stays for one more turn.
                hash_next        = fnv_absorb(hash_reg, q_rd.op.val);
                count_next       = (count_reg < COUNT_CAP) ? count_reg + COUNT_W'(1) : count_reg;
                out_kind_next    = KIND_DATA;
                out_byte_next    = q_rd.op.val;
                out_digest_next  = 64'd0;
                out_count_next   = '0;
                out_run_end_next = !q_rd.op.last;
                data_done_next   = q_rd.op.last;
                pop              = !q_rd.op.last;
            end
            else
            begin
                out_kind_next    = KIND_SUMMARY;
                out_byte_next    = 8'd0;
                out_digest_next  = hash_reg ^ master_key;
                out_count_next   = count_reg;
                out_run_end_next = 1'b1;
                hash_next        = FNV_BASIS;
                count_next       = '0;
                data_done_next   = 1'b0;
                pop              = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= FNV_BASIS;
            count_reg     <= '0;
            data_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            data_done_reg <= data_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg    <= out_kind_next;
        out_byte_reg    <= out_byte_next;
        out_digest_reg  <= out_digest_next;
        out_count_reg   <= out_count_next;
        out_run_end_reg <= out_run_end_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.kind      = out_kind_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.digest    = out_digest_reg;
    assign out_ch.out_count = out_count_reg;
    assign out_ch.run_end   = out_run_end_reg;

endmodule

`default_nettype wire
